// File: src/sssd_pkg.sv
// Shared types, constants and the segment decoder for the seven-segment scan driver.
// No dependencies.
package sssd_pkg;

    typedef logic [4:0] code_t;

    typedef struct packed {
        logic [7:0] seg;
        logic [3:0] en;
    } pin_state_t;

    localparam logic KIND_REFRESH = 1'b0;
    localparam logic KIND_LOAD    = 1'b1;

    localparam code_t       CODE_BLANK = 5'd25;
    localparam logic [15:0] MAX_VALUE  = 16'd9999;
    localparam logic [13:0] LIMIT_3DIG = 14'd999;
    localparam logic [13:0] LIMIT_2DIG = 14'd99;
    localparam logic [13:0] LIMIT_1DIG = 14'd9;

    // Reciprocals, exact over 0..9999: x/10 = x*52429>>19, x/100 = x*5243>>19,
    // x/1000 = x*8389>>23
    localparam logic [15:0] RECIP_10   = 16'd52429;
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam logic [13:0] RECIP_1000 = 14'd8389;

    function automatic logic [7:0] seg_decode(input code_t code);
        logic [7:0] seg;
        unique case (code)
            5'd0:    seg = 8'b0011_1111;
            5'd1:    seg = 8'b0000_0110;
            5'd2:    seg = 8'b0101_1011;
            5'd3:    seg = 8'b0100_1111;
            5'd4:    seg = 8'b0110_0110;
            5'd5:    seg = 8'b0110_1101;
            5'd6:    seg = 8'b0111_1101;
            5'd7:    seg = 8'b0000_0111;
            5'd8:    seg = 8'b0111_1111;
            5'd9:    seg = 8'b0110_1111;
            default: seg = 8'b0000_0000;
        endcase
        return seg;
    endfunction

endpackage

// File: src/sssd_split.sv
// Binary to four decimal digit codes with leading-zero blanking.
// Depends on sssd_pkg.
module sssd_split (
    input  logic [15:0]        value,
    output logic               in_range,
    output sssd_pkg::code_t    codes [4]
);
    import sssd_pkg::*;

    logic [13:0] v;
    logic [29:0] p10;
    logic [26:0] p100;
    logic [27:0] p1000;
    logic [9:0]  q10;
    logic [6:0]  q100;
    logic [3:0]  q1000;
    logic [13:0] m10_q10;
    logic [9:0]  m10_q100;
    logic [6:0]  m10_q1000;
    logic [13:0] d0;
    logic [9:0]  d1;
    logic [6:0]  d2;

    assign in_range = (value <= MAX_VALUE);
    assign v        = value[13:0];

    assign p10   = 30'(v) * 30'(RECIP_10);
    assign p100  = 27'(v) * 27'(RECIP_100);
    assign p1000 = 28'(v) * 28'(RECIP_1000);

    assign q10   = p10[28:19];
    assign q100  = p100[25:19];
    assign q1000 = p1000[26:23];

    // times ten as shift and add
    assign m10_q10   = 14'({q10, 3'b000})  + 14'({q10, 1'b0});
    assign m10_q100  = 10'({q100, 3'b000}) + 10'({q100, 1'b0});
    assign m10_q1000 = 7'({q1000, 3'b000}) + 7'({q1000, 1'b0});

    assign d0 = v - m10_q10;
    assign d1 = q10 - m10_q100;
    assign d2 = q100 - m10_q1000;

    assign codes[0] = {1'b0, d0[3:0]};
    assign codes[1] = (v <= LIMIT_1DIG) ? CODE_BLANK : {1'b0, d1[3:0]};
    assign codes[2] = (v <= LIMIT_2DIG) ? CODE_BLANK : {1'b0, d2[3:0]};
    assign codes[3] = (v <= LIMIT_3DIG) ? CODE_BLANK : {1'b0, q1000};

endmodule

// File: src/sssd_scan.sv
// Display state: digit codes, scan pointer and the logical segment/enable latches.
// Depends on sssd_pkg and sssd_split.
module sssd_scan (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   kind,
    input  logic [15:0]            value,
    output sssd_pkg::pin_state_t   latch_next
);
    import sssd_pkg::*;

    code_t       codes_reg [4];
    code_t       codes_next [4];
    code_t       split_codes [4];
    logic        split_ok;
    logic [2:0]  ptr_reg;
    logic [2:0]  ptr_next;
    pin_state_t  latch_reg;

    sssd_split u_split (
        .value    (value),
        .in_range (split_ok),
        .codes    (split_codes)
    );

    always_comb
    begin
        codes_next = codes_reg;
        ptr_next   = ptr_reg;
        latch_next = latch_reg;
        if (step)
        begin
            if (kind == KIND_LOAD)
            begin
                if (split_ok)
                    codes_next = split_codes;
            end
            else
            begin
                latch_next.en = 4'b0000;
                if (!ptr_reg[2])
                begin
                    latch_next.seg = seg_decode(codes_reg[ptr_reg[1:0]]);
                    latch_next.en  = 4'b0001 << ptr_reg[1:0];
                    ptr_next       = ptr_reg + 3'd1;
                end
                else
                begin
                    // fifth slot: all dark, segments kept
                    ptr_next = 3'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                codes_reg[i] <= CODE_BLANK;
            ptr_reg   <= 3'd0;
            latch_reg <= '0;
        end
        else
        begin
            codes_reg <= codes_next;
            ptr_reg   <= ptr_next;
            latch_reg <= latch_next;
        end
    end

endmodule

// File: src/seven_segment_scan_driver.sv
// Top level of the four-digit multiplexed seven-segment scan driver.
// Depends on sssd_pkg and sssd_scan.
//
// Input channel (in_valid/in_ready, kind, display_value): kind 1 loads a
// value of 0..9999 into the four digits (leading zeros blanked, units kept);
// larger values are ignored. kind 0 is a refresh tick that lights the next
// digit in a five-slot scan (four digits and one dark slot).
// Output channel (out_valid/out_ready, segment_pins, digit_pins): one word
// per input word, the pin levels after that word, in order.
// cfg_we/cfg_wdata selects pin polarity (1 inverts all pins for common
// anode wiring); write it while idle.
// Timing: an accepted word passes the input register, then the result register,
// which raises out_valid; an output stall can hold it in the input register.
// Throughput: one word per cycle while out_ready stays high, limited only by the single-stage update
// of the display state.
// When the receiver stalls, the result register holds and the input
// register takes one more word; in_ready then drops until out_ready.
// Reset: digits blank, scan pointer zero, latches dark, common cathode,
// both channels empty; the pin ports are undefined until the first result.
module seven_segment_scan_driver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [15:0] display_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  segment_pins,
    output logic [3:0]  digit_pins
);
    import sssd_pkg::*;

    logic        anode_reg;
    logic        s1_valid_reg;
    logic        s1_kind_reg;
    logic [15:0] s1_value_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  seg_reg;
    logic [3:0]  dig_reg;
    logic        advance;
    logic        in_take;
    pin_state_t  latch_next;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    sssd_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .kind       (s1_kind_reg),
        .value      (s1_value_reg),
        .latch_next (latch_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anode_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                anode_reg <= cfg_wdata;
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_kind_reg  <= kind;
            s1_value_reg <= display_value;
        end
        if (advance)
        begin
            seg_reg <= anode_reg ? ~latch_next.seg : latch_next.seg;
            dig_reg <= anode_reg ? latch_next.en : ~latch_next.en;
        end
    end

    assign out_valid    = out_valid_reg;
    assign segment_pins = seg_reg;
    assign digit_pins   = dig_reg;

endmodule

// File: src/sssd_checker.sv
// Port-level checks for the seven-segment scan driver, bound to the top level.
// Depends on seven_segment_scan_driver ports only.
module sssd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  segment_pins,
    input logic [3:0]  digit_pins
);

    // at most one digit on, whichever polarity
    a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($onehot0(digit_pins) || $onehot0(~digit_pins)))
        else $error("more than one digit enabled");

    // after an accept the result register holds a word
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##2 out_valid)
        else $error("result missing after accepted word");

    // input only backs up when the result register is full and stalled
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low without output stall");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(segment_pins) && $stable(digit_pins)))
        else $error("stalled output word changed");

endmodule

bind seven_segment_scan_driver sssd_checker u_sssd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .segment_pins (segment_pins),
    .digit_pins   (digit_pins)
);

// File: tb/sssd_pin_checker.sv
// Checker for the seven-segment scan driver: watches both channels and the config port,
// keeps its own copy of the display state and compares every output word in order.
// Depends on sssd_pkg (code_t, pin_state_t, KIND_LOAD, CODE_BLANK, MAX_VALUE).
module sssd_pin_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        kind,
    input  logic [15:0] display_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  segment_pins,
    input  logic [3:0]  digit_pins,
    output int          mismatches,
    output int          pending,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import sssd_pkg::*;

    pin_state_t  pending_pins[$];
    code_t       shown_codes[4];
    logic [2:0]  scan_pos    = 3'd0;
    logic [7:0]  lit_segs    = 8'd0;
    logic [3:0]  lit_digits  = 4'd0;
    logic        anode_mode  = 1'b0;
    pin_state_t  want;
    pin_state_t  pins;
    int unsigned val;
    int          mismatch_count = 0;
    int          checked_count  = 0;
    int          queued_count   = 0;

    assign mismatches   = mismatch_count;
    assign results_seen = checked_count;
    assign pending      = queued_count;

    function automatic logic [7:0] digit_glyph(input code_t c);
        logic [7:0] g;
        unique case (c)
            5'd0:    g = 8'h3F;
            5'd1:    g = 8'h06;
            5'd2:    g = 8'h5B;
            5'd3:    g = 8'h4F;
            5'd4:    g = 8'h66;
            5'd5:    g = 8'h6D;
            5'd6:    g = 8'h7D;
            5'd7:    g = 8'h07;
            5'd8:    g = 8'h7F;
            5'd9:    g = 8'h6F;
            default: g = 8'h00;   // blank code lights nothing
        endcase
        return g;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned want_v);
        $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got_v, want_v);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_pins.delete();
            for (int i = 0; i < 4; i++)
                shown_codes[i] = CODE_BLANK;
            scan_pos     = 3'd0;
            lit_segs     = 8'd0;
            lit_digits   = 4'd0;
            anode_mode   = 1'b0;
            queued_count <= 0;
        end
        else
        begin
            // compare first: a word leaving now belongs to an earlier input word
            if (out_valid && out_ready)
            begin
                if (pending_pins.size() == 0)
                begin
                    report_mismatch("output word with nothing expected",
                                    32'({segment_pins, digit_pins}), 32'd0);
                end
                else
                begin
                    want = pending_pins.pop_front();
                    checked_count++;
                    if (segment_pins !== want.seg)
                        report_mismatch("segment_pins", 32'(segment_pins), 32'(want.seg));
                    if (digit_pins !== want.en)
                        report_mismatch("digit_pins", 32'(digit_pins), 32'(want.en));
                end
            end

            if (in_valid && in_ready)
            begin
                if (kind == KIND_LOAD)
                begin
                    if (display_value <= MAX_VALUE)
                    begin
                        val = 32'(display_value);
                        shown_codes[0] = code_t'(val % 10);
                        shown_codes[1] = (val > 9)   ? code_t'((val / 10) % 10)  : CODE_BLANK;
                        shown_codes[2] = (val > 99)  ? code_t'((val / 100) % 10) : CODE_BLANK;
                        shown_codes[3] = (val > 999) ? code_t'(val / 1000)       : CODE_BLANK;
                    end
                end
                else
                begin
                    lit_digits = 4'd0;
                    if (scan_pos <= 3'd3)
                    begin
                        lit_segs   = digit_glyph(shown_codes[scan_pos[1:0]]);
                        lit_digits = 4'd1 << scan_pos[1:0];
                        scan_pos   = scan_pos + 3'd1;
                    end
                    else
                    begin
                        scan_pos = 3'd0;   // dark slot: segments stay latched
                    end
                end
                pins.seg = anode_mode ? ~lit_segs  : lit_segs;
                pins.en  = anode_mode ? lit_digits : ~lit_digits;
                pending_pins.push_back(pins);
            end

            if (cfg_we)
                anode_mode = cfg_wdata;

            queued_count <= pending_pins.size();
        end
    end

endmodule

// File: tb/tb.sv
// Top of the scan driver testbench: clock, reset, stimulus, idling and the verdict.
// Depends on sssd_pkg, seven_segment_scan_driver and sssd_pin_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sssd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 60;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic        cfg_wdata     = 1'b0;
    logic        in_valid      = 1'b0;
    logic        kind          = KIND_REFRESH;
    logic [15:0] display_value = 16'd0;
    logic        out_ready     = 1'b0;
    wire         in_ready;
    wire         out_valid;
    wire  [7:0]  segment_pins;
    wire  [3:0]  digit_pins;

    int mismatches;
    int pending;
    int results_seen;

    int   cycle_count  = 0;
    int   words_sent   = 0;
    int   loads_sent   = 0;
    int   ignored_sent = 0;
    int   ticks_sent   = 0;
    logic tx_burst     = 1'b0;
    logic rx_burst     = 1'b0;
    logic hold_active  = 1'b0;
    int   rx_stall     = 0;
    int   rx_cycle     = 0;

    seven_segment_scan_driver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .display_value (display_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .segment_pins  (segment_pins),
        .digit_pins    (digit_pins)
    );

    sssd_pin_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .display_value (display_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .segment_pins  (segment_pins),
        .digit_pins    (digit_pins),
        .mismatches    (mismatches),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int send_gap();
        if (hold_active || tx_burst)
            return 0;
        if ($urandom_range(0, 99) < 55)
            return 0;
        return idle_len();
    endfunction

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, stall-free stretches, and the long hold-off
    always @(posedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_burst = ($urandom_range(0, 3) == 0);
        if (!rst_n || hold_active)
            out_ready <= 1'b0;
        else if (rx_stall > 0)
        begin
            rx_stall--;
            out_ready <= 1'b0;
        end
        else if (!rx_burst && $urandom_range(0, 99) < 25)
        begin
            rx_stall = idle_len() - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // long hold-off mid run so the block fills and drops in_ready
    initial
    begin
        wait (words_sent >= 420);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    task automatic drive_word(input logic k, input logic [15:0] v);
        int gap;
        gap = send_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        display_value <= v;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        words_sent++;
        if (k == KIND_LOAD && v > MAX_VALUE)
            ignored_sent++;
        else if (k == KIND_LOAD)
            loads_sent++;
        else
            ticks_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_polarity(input logic anode);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= anode;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_word();
        logic [15:0] v;
        int          s;
        if ($urandom_range(0, 99) < 70)
        begin
            drive_word(KIND_REFRESH, 16'($urandom));   // value is don't-care on a tick
        end
        else
        begin
            s = $urandom_range(0, 19);
            if (s < 3)
                v = 16'($urandom_range(0, 9));
            else if (s < 6)
                v = 16'($urandom_range(10, 99));
            else if (s < 10)
                v = 16'($urandom_range(100, 999));
            else if (s < 15)
                v = 16'($urandom_range(1000, 9999));
            else if (s == 15)
                v = $urandom_range(0, 1) ? MAX_VALUE : MAX_VALUE + 16'd1;
            else
                v = 16'($urandom_range(10000, 65535));
            drive_word(KIND_LOAD, v);
        end
    endtask

    initial
    begin
        logic anode_seq[3];
        int   words_seq[3];
        anode_seq = '{1'b1, 1'b0, 1'b1};
        words_seq = '{280, 280, 290};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: blank scan with dark slot, digit-count edges, ignored loads
        set_polarity(1'b0);
        repeat (5) drive_word(KIND_REFRESH, 16'h0000);
        drive_word(KIND_LOAD, 16'd9999);
        repeat (5) drive_word(KIND_REFRESH, 16'hFFFF);
        drive_word(KIND_LOAD, 16'hFFFF);
        repeat (2) drive_word(KIND_REFRESH, 16'h0000);
        drive_word(KIND_LOAD, 16'd10000);
        drive_word(KIND_LOAD, 16'd7);
        repeat (3) drive_word(KIND_REFRESH, 16'h0000);
        drive_word(KIND_LOAD, 16'd0);
        drive_word(KIND_REFRESH, 16'h0000);
        drive_word(KIND_LOAD, 16'd10);
        drive_word(KIND_LOAD, 16'd100);
        drive_word(KIND_LOAD, 16'd1000);
        drive_word(KIND_REFRESH, 16'h0000);

        for (int p = 0; p < 3; p++)
        begin
            set_polarity(anode_seq[p]);
            for (int n = 0; n < words_seq[p]; n++)
            begin
                if (n % 40 == 0)
                    tx_burst = ($urandom_range(0, 3) == 0);
                random_word();
            end
        end
        tx_burst = 1'b0;

        drain();
        repeat (10) @(posedge clk);

        $display("Run covered %0d loads, %0d out-of-range loads, %0d refresh ticks",
                 loads_sent, ignored_sent, ticks_sent);
        $display("under both pin polarities; %0d output words checked, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
src/sssd_pkg.sv
src/sssd_split.sv
src/sssd_scan.sv
src/seven_segment_scan_driver.sv
src/sssd_checker.sv
tb/sssd_pin_checker.sv
tb/tb.sv
